@@ src/dtw_distance_2d_curves_assert.svh @@
// assertion macros for the dtw block
`ifndef DTW_DISTANCE_2D_CURVES_ASSERT_SVH
`define DTW_DISTANCE_2D_CURVES_ASSERT_SVH

// implication checked every clock, quiet during reset
`define DTW_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtw check failed");

// next-cycle implication, quiet during reset
`define DTW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtw check failed");

`endif

@@ src/dtw_pkg.sv @@
// ----------------------------------------------------------------------------
// dtw_pkg
// types and constants shared by the dtw distance block
// ----------------------------------------------------------------------------
package dtw_pkg;

   localparam logic [1:0] FUNC_APPEND_A = 2'd0;
   localparam logic [1:0] FUNC_APPEND_B = 2'd1;
   localparam logic [1:0] FUNC_COMPUTE  = 2'd2;

   localparam int DIST_W = 48;
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              infinite;
      logic              saturated;
      logic              points_dropped;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RDA,
      ST_RDB,
      ST_DIFF,
      ST_SQX,
      ST_SQY,
      ST_SQRT,
      ST_ACC,
      ST_OUT
   } state_type;

endpackage

@@ src/dtw_sqrt.sv @@
// ----------------------------------------------------------------------------
// dtw_sqrt
// bit-serial integer square root of a 67-bit value, one result bit per cycle
// ----------------------------------------------------------------------------
module dtw_sqrt import dtw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [66:0] radicand,
   output logic        done,
   output logic [32:0] root
);

   logic [67:0] rem_ff, rem_in;
   logic [66:0] val_ff, val_in;
   logic [32:0] root_ff, root_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [67:0] shifted;
   logic [67:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      val_in  = val_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      shifted = {rem_ff[65:0], val_ff[66:65]};
      trial   = {33'd0, root_ff, 2'b01};
      if (start) begin
         rem_in  = '0;
         val_in  = {radicand[65:0], 1'b0};
         root_in = '0;
         cnt_in  = 6'd33;
         busy_in = 1'b1;
         rem_in  = {66'd0, 1'b0, radicand[66]};
         if (radicand[66]) begin
            rem_in  = '0;
            root_in = 33'd1;
         end
      end else if (busy_ff) begin
         val_in = {val_ff[64:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = shifted - trial;
            root_in = {root_ff[31:0], 1'b1};
         end else begin
            rem_in  = shifted;
            root_in = {root_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      val_ff  <= val_in;
      root_ff <= root_in;
   end

   assign done = busy_ff && (cnt_ff == 6'd1);
   assign root = root_in;

endmodule

@@ src/dtw_distance_2d_curves.sv @@
// ----------------------------------------------------------------------------
// dtw_distance_2d_curves
// dynamic time warping distance between two curves of 2d points
//
// req channel: func 0 appends a point to curve a, func 1 to curve b,
// func 2 runs the warping recurrence, sends one rsp transfer and clears
// both curves; func 3 is dropped.
// a compute visits all n*m cells for curves of n and m points before
// rsp_valid rises, and goes straight to rsp when either curve is empty:
// each cell goes through one shared 33x33 multiplier twice and a
// bit-serial square root of 33 steps, plus a read, a difference and an
// accumulate step; each row adds one read step.
// req_ready is low from compute start until the rsp transfer is taken,
// so a stalled receiver holds the block. reset empties both curves and
// clears the drop flag; curve and cost memories are not cleared.
// ----------------------------------------------------------------------------
module dtw_distance_2d_curves import dtw_pkg::*; #(
   parameter int MAX_POINTS = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   logic [63:0] mem_a [MAX_POINTS];
   logic [63:0] mem_b [MAX_POINTS];
   logic [DIST_W-1:0] mem_c [MAX_POINTS];

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   logic drop_ff, drop_in, sat_ff, sat_in;
   logic [63:0] pa_ff, pb_ff;
   logic [32:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [66:0] sum_ff, sum_in;
   logic [DIST_W-1:0] up_ff, left_ff, left_in, diag_ff, diag_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic inf_ff, inf_in;
   logic [DIST_W-1:0] rdc_ff;

   logic [32:0] mul_op;
   logic [65:0] mul_p;
   logic sq_start, sq_done;
   logic [32:0] sq_root;
   logic [DIST_W-1:0] best;
   logic [DIST_W:0] tot;
   logic [DIST_W-1:0] cell_sum;
   logic [32:0] ddx, ddy;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = '{distance: dist_ff, infinite: inf_ff, saturated: sat_ff,
                        points_dropped: drop_ff};

   assign mul_op = (state_ff == ST_SQX) ? dx_ff : dy_ff;
   assign mul_p  = mul_op * mul_op;
   assign ddx = {pa_ff[31], pa_ff[31:0]} - {pb_ff[31], pb_ff[31:0]};
   assign ddy = {pa_ff[63], pa_ff[63:32]} - {pb_ff[63], pb_ff[63:32]};

   dtw_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .radicand(sum_in),
      .done(sq_done), .root(sq_root)
   );

   // the row entry j-1 holds D(i-1, j) once read; left holds D(i, j-1)
   always_comb begin
      if (i_ff == CW'(1)) best = (j_ff == CW'(1)) ? '0 : left_ff;
      else if (j_ff == CW'(1)) best = up_ff;
      else begin
         best = (up_ff < left_ff) ? up_ff : left_ff;
         if (diag_ff < best) best = diag_ff;
      end
      tot      = {1'b0, best} + {{(DIST_W-32){1'b0}}, sq_root};
      cell_sum = (tot >= {1'b0, DIST_MAX}) ? DIST_MAX : tot[DIST_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_data.func == FUNC_COMPUTE) begin
               if ((cnt_a_ff == '0) != (cnt_b_ff == '0)) state_in = ST_OUT;
               else if (cnt_a_ff == '0) state_in = ST_OUT;
               else state_in = ST_RDA;
            end
         end
         ST_RDA:  state_in = ST_RDB;
         ST_RDB:  state_in = ST_DIFF;
         ST_DIFF: state_in = ST_SQX;
         ST_SQX:  state_in = ST_SQY;
         ST_SQY:  state_in = ST_SQRT;
         ST_SQRT: if (sq_done) state_in = ST_ACC;
         ST_ACC: begin
            if (j_ff == cnt_b_ff && i_ff == cnt_a_ff) state_in = ST_OUT;
            else if (j_ff == cnt_b_ff) state_in = ST_RDA;
            else state_in = ST_RDB;
         end
         ST_OUT:  if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cnt_a_in = cnt_a_ff;
      cnt_b_in = cnt_b_ff;
      drop_in  = drop_ff;
      sat_in   = sat_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      sum_in   = sum_ff;
      left_in  = left_ff;
      diag_in  = diag_ff;
      dist_in  = dist_ff;
      inf_in   = inf_ff;
      sq_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.func)
                  FUNC_APPEND_A: begin
                     if (cnt_a_ff < CW'(MAX_POINTS)) cnt_a_in = cnt_a_ff + CW'(1);
                     else drop_in = 1'b1;
                  end
                  FUNC_APPEND_B: begin
                     if (cnt_b_ff < CW'(MAX_POINTS)) cnt_b_in = cnt_b_ff + CW'(1);
                     else drop_in = 1'b1;
                  end
                  FUNC_COMPUTE: begin
                     sat_in  = 1'b0;
                     dist_in = '0;
                     inf_in  = (cnt_a_ff == '0) != (cnt_b_ff == '0);
                     i_in    = CW'(1);
                     j_in    = CW'(0);
                  end
                  default: ;
               endcase
            end
         end
         ST_RDA: begin
            j_in    = CW'(1);
            left_in = '0;
         end
         ST_DIFF: begin
            dx_in = ddx[32] ? -ddx : ddx;
            dy_in = ddy[32] ? -ddy : ddy;
            diag_in = (j_ff == CW'(1)) ? '0 : diag_ff;
         end
         ST_SQX: sum_in = {1'b0, mul_p};
         ST_SQY: begin
            sum_in   = sum_ff + {1'b0, mul_p};
            sq_start = 1'b1;
         end
         ST_ACC: begin
            if (cell_sum == DIST_MAX) sat_in = 1'b1;
            left_in = cell_sum;
            diag_in = up_ff;
            dist_in = cell_sum;
            if (j_ff == cnt_b_ff) begin
               i_in = i_ff + CW'(1);
            end else begin
               j_in = j_ff + CW'(1);
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               cnt_a_in = '0;
               cnt_b_in = '0;
               drop_in  = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_a_ff <= '0;
         cnt_b_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_a_ff <= cnt_a_in;
         cnt_b_ff <= cnt_b_in;
         drop_ff  <= drop_in;
      end
      sat_ff  <= sat_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      sum_ff  <= sum_in;
      left_ff <= left_in;
      diag_ff <= diag_in;
      dist_ff <= dist_in;
      inf_ff  <= inf_in;
   end

   // point memories
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         if (req_data.func == FUNC_APPEND_A && cnt_a_ff < CW'(MAX_POINTS))
            mem_a[cnt_a_ff[AW-1:0]] <= {req_data.coord_y, req_data.coord_x};
         if (req_data.func == FUNC_APPEND_B && cnt_b_ff < CW'(MAX_POINTS))
            mem_b[cnt_b_ff[AW-1:0]] <= {req_data.coord_y, req_data.coord_x};
      end
      if (state_ff == ST_RDA) pa_ff <= mem_a[AW'(i_ff - CW'(1))];
      if (state_ff == ST_RDB) pb_ff <= mem_b[AW'(j_ff - CW'(1))];
   end

   // cost row, entry j-1 holds D(.,j)
   always_ff @(posedge clock) begin
      if (state_ff == ST_ACC) mem_c[AW'(j_ff - CW'(1))] <= cell_sum;
      if (state_ff == ST_RDB) rdc_ff <= mem_c[AW'(j_ff - CW'(1))];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DIFF) up_ff <= rdc_ff;
   end

endmodule

@@ src/dtw_checker.sv @@
// ----------------------------------------------------------------------------
// dtw_checker
// port-level checks of the dtw distance block
// ----------------------------------------------------------------------------
`include "dtw_distance_2d_curves_assert.svh"

module dtw_checker import dtw_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   `DTW_ASSERT_IMP(a_excl, clock, reset, rsp_valid, !req_ready)
   `DTW_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `DTW_ASSERT_IMP(a_inf, clock, reset, rsp_valid && rsp_data.infinite, rsp_data.distance == '0 && !rsp_data.saturated)
   `DTW_ASSERT_NEXT(a_point, clock, reset, req_valid && req_ready && req_data.func != FUNC_COMPUTE, req_ready)

endmodule

bind dtw_distance_2d_curves dtw_checker u_dtw_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_data(req_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_data(rsp_data)
);
